// ===== hw/rtl/pit_pkg.sv =====
package pit_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int GID_BITS_DEF = 16;
  localparam int SLOT_W       = 6;
  localparam int ID_W         = 16;
  localparam int MASK_W       = 64;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_SLOT2ID = 3'd2,
    CMD_ID2SLOT = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_COMPACT = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_POP, S_WRITE, S_LOOK, S_LOOKR, S_COUNT, S_MAP, S_EMIT
  } state_t;

  typedef struct packed {
    logic  latch;
    logic  scan_from1;
    logic  scan;
    logic  look;
    logic  lookr;
    logic  pop_rd;
    logic  take_pop;
    logic  set_new;
    logic  wr_add;
    logic  set_hit;
    logic  rm;
    logic  clr;
    logic  cnt;
    logic  cmp_fix;
    logic  cmp_emit;
    logic  emit;
    stat_t stat;
  } dp_cmd_t;

  typedef struct packed {
    logic id_zero;
    logic hit;
    logic miss;
    logic free_nz;
    logic free_full;
    logic tbl_full;
    logic look_ok;
    logic row;
    logic last_row;
  } dp_stat_t;

  function automatic logic [3:0] bits_for(logic [7:0] h);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if ((9'd1 << b) < ({1'b0, h} + 9'd1)) n = 4'(b + 1);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/palette_index_table.sv =====
// Palette index table: maps global type ids to local slots, slot 0 holding the
// empty type. A request is taken when start is high and busy low; results come
// out one per cycle with out_valid and cannot be held off, so the receiver must
// take every strobe. busy stays high while a request is worked on, and a single
// result shows in the first cycle with busy low again. Add, remove and
// id-to-slot walk the slot memory one entry a cycle through its single read
// port. An add that misses reuses a freed slot if there is one, else opens a
// new slot, else reports a full table. Slot-to-id reads the entry at the given
// index, and clear and unknown commands go straight to their result.
// Compact walks the table twice, once to count kept slots and once to move
// them. Its results come one a cycle during the second walk, and the last
// one shows as busy drops. A new request may be taken in the cycle the last
// result shows.
module palette_index_table #(
  parameter int PALETTE_DEPTH  = pit_pkg::DEPTH_DEF,
  parameter int GLOBAL_ID_BITS = pit_pkg::GID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_command,
  input  logic [pit_pkg::ID_W-1:0]     in_global_id,
  input  logic [pit_pkg::SLOT_W-1:0]   in_local_index,
  input  logic [pit_pkg::MASK_W-1:0]   in_used_mask,
  output logic                         out_valid,
  output logic [pit_pkg::SLOT_W-1:0]   out_local_index_res,
  output logic [pit_pkg::SLOT_W-1:0]   out_mapped_index,
  output logic [pit_pkg::ID_W-1:0]     out_global_id_res,
  output logic [1:0]                   out_status,
  output logic [2:0]                   out_bits_needed,
  output logic                         out_last
);

  pit_pkg::dp_cmd_t  cmd;
  pit_pkg::dp_stat_t st;

  pit_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .st_i       (st),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  pit_dp #(
    .PALETTE_DEPTH  (PALETTE_DEPTH),
    .GLOBAL_ID_BITS (GLOBAL_ID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_i               (cmd),
    .st_o                (st),
    .in_global_id        (in_global_id),
    .in_local_index      (in_local_index),
    .in_used_mask        (in_used_mask),
    .out_valid           (out_valid),
    .out_local_index_res (out_local_index_res),
    .out_mapped_index    (out_mapped_index),
    .out_global_id_res   (out_global_id_res),
    .out_status          (out_status),
    .out_bits_needed     (out_bits_needed),
    .out_last            (out_last)
  );

endmodule

// ===== hw/rtl/pit_ctrl.sv =====
module pit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_command,
  input  pit_pkg::dp_stat_t st_i,
  output pit_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);

  pit_pkg::state_t state_r, state_nxt;
  pit_pkg::cmd_t   req_r, req_nxt;
  pit_pkg::stat_t  stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pit_pkg::S_IDLE;
      req_r   <= pit_pkg::CMD_ADD;
      stat_r  <= pit_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    stat_nxt  = stat_r;
    cmd_o     = '0;
    cmd_o.stat = stat_r;
    case (state_r)
      pit_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.latch      = 1'b1;
          cmd_o.scan_from1 = 1'b1;
          req_nxt          = pit_pkg::cmd_t'(in_command);
          stat_nxt         = pit_pkg::ST_OK;
          case (pit_pkg::cmd_t'(in_command))
            pit_pkg::CMD_ADD, pit_pkg::CMD_REMOVE, pit_pkg::CMD_ID2SLOT:
              state_nxt = pit_pkg::S_FIND;
            pit_pkg::CMD_SLOT2ID: state_nxt = pit_pkg::S_LOOK;
            pit_pkg::CMD_CLEAR: begin
              cmd_o.clr = 1'b1;
              state_nxt = pit_pkg::S_EMIT;
            end
            pit_pkg::CMD_COMPACT: state_nxt = pit_pkg::S_COUNT;
            default: begin
              stat_nxt  = pit_pkg::ST_MISS;
              state_nxt = pit_pkg::S_EMIT;
            end
          endcase
        end
      end
      pit_pkg::S_FIND: begin
        if (st_i.id_zero) begin
          stat_nxt  = (req_r == pit_pkg::CMD_REMOVE) ? pit_pkg::ST_MISS : pit_pkg::ST_OK;
          state_nxt = pit_pkg::S_EMIT;
        end else if (st_i.hit) begin
          state_nxt = pit_pkg::S_EMIT;
          if (req_r == pit_pkg::CMD_REMOVE && st_i.free_full) begin
            stat_nxt = pit_pkg::ST_MISS;
          end else begin
            cmd_o.set_hit = 1'b1;
            cmd_o.rm      = (req_r == pit_pkg::CMD_REMOVE);
            stat_nxt      = pit_pkg::ST_OK;
          end
        end else if (st_i.miss) begin
          if (req_r != pit_pkg::CMD_ADD) begin
            stat_nxt  = pit_pkg::ST_MISS;
            state_nxt = pit_pkg::S_EMIT;
          end else if (st_i.free_nz) begin
            cmd_o.pop_rd = 1'b1;
            state_nxt    = pit_pkg::S_POP;
          end else if (!st_i.tbl_full) begin
            cmd_o.set_new = 1'b1;
            state_nxt     = pit_pkg::S_WRITE;
          end else begin
            stat_nxt  = pit_pkg::ST_FULL;
            state_nxt = pit_pkg::S_EMIT;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      pit_pkg::S_POP: begin
        cmd_o.take_pop = 1'b1;
        state_nxt      = pit_pkg::S_WRITE;
      end
      pit_pkg::S_WRITE: begin
        cmd_o.wr_add = 1'b1;
        stat_nxt     = pit_pkg::ST_OK;
        state_nxt    = pit_pkg::S_EMIT;
      end
      pit_pkg::S_LOOK: begin
        cmd_o.look = 1'b1;
        state_nxt  = pit_pkg::S_LOOKR;
      end
      pit_pkg::S_LOOKR: begin
        cmd_o.lookr = 1'b1;
        stat_nxt    = st_i.look_ok ? pit_pkg::ST_OK : pit_pkg::ST_MISS;
        state_nxt   = pit_pkg::S_EMIT;
      end
      pit_pkg::S_COUNT: begin
        cmd_o.cnt = st_i.row;
        if (st_i.miss) begin
          cmd_o.cmp_fix = 1'b1;
          state_nxt     = pit_pkg::S_MAP;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      pit_pkg::S_MAP: begin
        cmd_o.scan     = 1'b1;
        cmd_o.cmp_emit = st_i.row;
        if (st_i.last_row) state_nxt = pit_pkg::S_IDLE;
      end
      pit_pkg::S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_nxt  = pit_pkg::S_IDLE;
      end
      default: state_nxt = pit_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != pit_pkg::S_IDLE);

endmodule

// ===== hw/rtl/pit_dp.sv =====
module pit_dp #(
  parameter int PALETTE_DEPTH  = pit_pkg::DEPTH_DEF,
  parameter int GLOBAL_ID_BITS = pit_pkg::GID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pit_pkg::dp_cmd_t             cmd_i,
  output pit_pkg::dp_stat_t            st_o,
  input  logic [pit_pkg::ID_W-1:0]     in_global_id,
  input  logic [pit_pkg::SLOT_W-1:0]   in_local_index,
  input  logic [pit_pkg::MASK_W-1:0]   in_used_mask,
  output logic                         out_valid,
  output logic [pit_pkg::SLOT_W-1:0]   out_local_index_res,
  output logic [pit_pkg::SLOT_W-1:0]   out_mapped_index,
  output logic [pit_pkg::ID_W-1:0]     out_global_id_res,
  output logic [1:0]                   out_status,
  output logic [2:0]                   out_bits_needed,
  output logic                         out_last
);

  localparam int IW  = $clog2(PALETTE_DEPTH);
  localparam int CW  = $clog2(PALETTE_DEPTH + 1);
  localparam int IDW = GLOBAL_ID_BITS;

  logic [IDW-1:0] slot_mem [PALETTE_DEPTH];
  logic [IW-1:0]  free_mem [PALETTE_DEPTH];

  logic [IDW-1:0]                 id_r, rd_r, res_gid_r;
  logic [pit_pkg::SLOT_W-1:0]     li_r, res_slot_r;
  logic [pit_pkg::MASK_W-1:0]     mask_r;
  logic [IW-1:0]                  free_rd_r, highest_r, addr_q_r, tgt_r;
  logic [CW-1:0]                  slot_count_r, free_count_r, oldc_r, ptr_r, kept_r;
  logic                           live_r, vld_r, zero_q_r, look_ok_r;

  logic                           out_valid_r, out_last_r;
  logic [pit_pkg::SLOT_W-1:0]     out_slot_r, out_map_r;
  logic [pit_pkg::ID_W-1:0]       out_gid_r;
  logic [1:0]                     out_stat_r;
  logic [2:0]                     out_bits_r;

  logic [IDW-1:0] rd_id, mem_wd;
  logic [IW-1:0]  mem_wa, mem_ra;
  logic           mem_we, kp, kept2, row, last_row, look_ok;

  assign rd_id    = zero_q_r ? '0 : rd_r;
  assign row      = live_r && vld_r;
  assign last_row = row && ((CW'(addr_q_r) + 1'b1) == oldc_r);
  assign kp       = (rd_id != '0) && (32'(addr_q_r) < 32'd64) && mask_r[6'(addr_q_r)];
  assign kept2    = (addr_q_r == '0) || kp;
  assign look_ok  = (32'(li_r) < 32'(slot_count_r)) && (32'(li_r) < PALETTE_DEPTH);

  assign st_o.id_zero   = (id_r == '0);
  assign st_o.hit       = row && (rd_id == id_r);
  assign st_o.miss      = live_r && !vld_r;
  assign st_o.free_nz   = (free_count_r != '0);
  assign st_o.free_full = (32'(free_count_r) >= PALETTE_DEPTH);
  assign st_o.tbl_full  = (32'(slot_count_r) >= PALETTE_DEPTH);
  assign st_o.look_ok   = look_ok_r;
  assign st_o.row       = row;
  assign st_o.last_row  = last_row;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = tgt_r;
    mem_wd = id_r;
    if (cmd_i.wr_add) begin
      mem_we = 1'b1;
    end else if (cmd_i.rm) begin
      mem_we = 1'b1;
      mem_wa = addr_q_r;
      mem_wd = '0;
    end else if (cmd_i.cmp_emit && kept2 && addr_q_r != '0) begin
      mem_we = 1'b1;
      mem_wa = kept_r[IW-1:0];
      mem_wd = rd_id;
    end
  end

  assign mem_ra = cmd_i.look ? IW'(li_r) : ptr_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_wa] <= mem_wd;
    rd_r <= slot_mem[mem_ra];
    if (cmd_i.rm) free_mem[free_count_r[IW-1:0]] <= addr_q_r;
    free_rd_r <= free_mem[free_count_r[IW-1:0] - 1'b1];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      id_r       <= IDW'({32'd0, in_global_id});
      li_r       <= in_local_index;
      mask_r     <= in_used_mask;
      oldc_r     <= slot_count_r;
      res_slot_r <= '0;
      res_gid_r  <= '0;
      kept_r     <= CW'(1);
    end
    if (cmd_i.scan) begin
      addr_q_r <= ptr_r[IW-1:0];
      vld_r    <= (ptr_r < oldc_r);
      zero_q_r <= (ptr_r == '0);
      ptr_r    <= ptr_r + 1'b1;
    end
    if (cmd_i.scan_from1) ptr_r <= CW'(1);
    if (cmd_i.look) begin
      zero_q_r  <= (li_r == '0);
      look_ok_r <= look_ok;
    end
    if (cmd_i.lookr) begin
      res_slot_r <= li_r;
      res_gid_r  <= look_ok_r ? rd_id : '0;
    end
    if (cmd_i.set_hit) begin
      tgt_r      <= addr_q_r;
      res_slot_r <= pit_pkg::SLOT_W'(addr_q_r);
    end
    if (cmd_i.take_pop) tgt_r <= free_rd_r;
    if (cmd_i.set_new)  tgt_r <= slot_count_r[IW-1:0];
    if (cmd_i.wr_add)   res_slot_r <= pit_pkg::SLOT_W'(tgt_r);
    if (cmd_i.cnt && kp) kept_r <= kept_r + 1'b1;
    if (cmd_i.cmp_fix) begin
      ptr_r  <= '0;
      kept_r <= CW'(1);
    end
    if (cmd_i.cmp_emit && kept2 && addr_q_r != '0) kept_r <= kept_r + 1'b1;
    if (cmd_i.emit) begin
      out_slot_r <= res_slot_r;
      out_map_r  <= '0;
      out_gid_r  <= pit_pkg::ID_W'(res_gid_r);
      out_stat_r <= cmd_i.stat;
      out_last_r <= 1'b1;
      out_bits_r <= 3'(pit_pkg::bits_for(8'(highest_r)));
    end
    if (cmd_i.cmp_emit) begin
      out_slot_r <= pit_pkg::SLOT_W'(addr_q_r);
      out_map_r  <= (kept2 && addr_q_r != '0) ? pit_pkg::SLOT_W'(kept_r) : '0;
      out_gid_r  <= pit_pkg::ID_W'(rd_id);
      out_stat_r <= kept2 ? pit_pkg::ST_OK : pit_pkg::ST_MISS;
      out_last_r <= last_row;
      out_bits_r <= 3'(pit_pkg::bits_for(8'(highest_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CW'(1);
      highest_r    <= '0;
      free_count_r <= '0;
      live_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit || cmd_i.cmp_emit;
      if (cmd_i.scan) live_r <= 1'b1;
      if (cmd_i.scan_from1 || cmd_i.cmp_fix) live_r <= 1'b0;
      if (cmd_i.rm) free_count_r <= free_count_r + 1'b1;
      if (cmd_i.pop_rd) free_count_r <= free_count_r - 1'b1;
      if (cmd_i.set_new) slot_count_r <= slot_count_r + 1'b1;
      if (cmd_i.wr_add && tgt_r > highest_r) highest_r <= tgt_r;
      if (cmd_i.clr) begin
        slot_count_r <= CW'(1);
        highest_r    <= '0;
        free_count_r <= '0;
      end
      if (cmd_i.cmp_fix) begin
        slot_count_r <= kept_r;
        highest_r    <= IW'(kept_r - 1'b1);
        free_count_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_local_index_res = out_slot_r;
  assign out_mapped_index    = out_map_r;
  assign out_global_id_res   = out_gid_r;
  assign out_status          = out_stat_r;
  assign out_bits_needed     = out_bits_r;
  assign out_last            = out_last_r;

endmodule

// ===== dv/palette_index_table_test.sv =====
`timescale 1ns / 1ps

module palette_index_table_test;
  import pit_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  command;
    logic [15:0] global_id;
    logic [5:0]  local_index;
    logic [63:0] used_mask;
    int          gap;
    bit          drain;
  } palette_req_t;

  typedef struct {
    logic [5:0]  slot;
    logic [5:0]  mapped;
    logic [15:0] id;
    stat_t       status;
    logic [2:0]  bits;
    logic        last;
  } palette_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [15:0] in_global_id;
  logic [5:0]  in_local_index;
  logic [63:0] in_used_mask;
  logic        out_valid;
  logic [5:0]  out_local_index_res;
  logic [5:0]  out_mapped_index;
  logic [15:0] out_global_id_res;
  logic [1:0]  out_status;
  logic [2:0]  out_bits_needed;
  logic        out_last;

  palette_index_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_global_id(in_global_id),
    .in_local_index(in_local_index), .in_used_mask(in_used_mask),
    .out_valid(out_valid), .out_local_index_res(out_local_index_res),
    .out_mapped_index(out_mapped_index), .out_global_id_res(out_global_id_res),
    .out_status(out_status), .out_bits_needed(out_bits_needed), .out_last(out_last)
  );

  palette_req_t pending_reqs[$];
  palette_res_t palette_expect[$];

  // shadow palette
  logic [15:0] slot_ids[DEPTH];
  logic [5:0]  freed_slots[DEPTH];
  int          slots_used;
  int          top_slot;
  int          freed_count;

  int errors;
  int reqs_taken;
  int results_seen;
  int full_seen;
  int compacts_seen;
  int hold_left;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [2:0] width_of_top();
    int b;
    b = 0;
    while ((1 << b) < top_slot + 1) b++;
    return 3'(b);
  endfunction

  function automatic int locate_id(logic [15:0] id);
    if (id == 16'd0) return 0;
    for (int i = 1; i < slots_used; i++)
      if (slot_ids[i] == id) return i;
    return -1;
  endfunction

  task automatic push_result(int slot, int mapped, logic [15:0] id, stat_t st, bit last);
    palette_res_t r;
    r.slot = 6'(slot);
    r.mapped = 6'(mapped);
    r.id = id;
    r.status = st;
    r.bits = width_of_top();
    r.last = last;
    palette_expect = {palette_expect, r};
  endtask

  task automatic palette_update(palette_req_t q);
    int s;
    int idx;
    int nxt;
    int old_used;
    logic [15:0] old_ids[DEPTH];
    int new_slot[DEPTH];
    bit kept[DEPTH];
    case (q.command)
      CMD_ADD: begin
        s = locate_id(q.global_id);
        if (s >= 0) push_result(s, 0, 0, ST_OK, 1);
        else if (freed_count > 0 || slots_used < DEPTH) begin
          if (freed_count > 0) begin
            freed_count--;
            idx = freed_slots[freed_count];
          end else begin
            idx = slots_used;
            slots_used++;
          end
          slot_ids[idx] = q.global_id;
          if (idx > top_slot) top_slot = idx;
          push_result(idx, 0, 0, ST_OK, 1);
        end else begin
          full_seen++;
          push_result(0, 0, 0, ST_FULL, 1);
        end
      end
      CMD_REMOVE: begin
        s = (q.global_id == 0) ? -1 : locate_id(q.global_id);
        if (s <= 0 || freed_count >= DEPTH) push_result(0, 0, 0, ST_MISS, 1);
        else begin
          slot_ids[s] = 16'd0;
          freed_slots[freed_count] = 6'(s);
          freed_count++;
          push_result(s, 0, 0, ST_OK, 1);
        end
      end
      CMD_SLOT2ID: begin
        if (q.local_index < slots_used)
          push_result(q.local_index, 0, slot_ids[q.local_index], ST_OK, 1);
        else push_result(q.local_index, 0, 0, ST_MISS, 1);
      end
      CMD_ID2SLOT: begin
        s = locate_id(q.global_id);
        if (s >= 0) push_result(s, 0, 0, ST_OK, 1);
        else push_result(0, 0, 0, ST_MISS, 1);
      end
      CMD_CLEAR: begin
        slot_ids[0] = 16'd0;
        slots_used = 1;
        top_slot = 0;
        freed_count = 0;
        push_result(0, 0, 0, ST_OK, 1);
      end
      CMD_COMPACT: begin
        compacts_seen++;
        old_used = slots_used;
        old_ids = slot_ids;
        nxt = 1;
        kept[0] = 1;
        new_slot[0] = 0;
        for (int i = 1; i < old_used; i++) begin
          kept[i] = old_ids[i] != 0 && q.used_mask[i];
          new_slot[i] = 0;
          if (kept[i]) begin
            slot_ids[nxt] = old_ids[i];
            new_slot[i] = nxt;
            nxt++;
          end
        end
        slot_ids[0] = 16'd0;
        slots_used = nxt;
        top_slot = nxt - 1;
        freed_count = 0;
        for (int i = 0; i < old_used; i++)
          push_result(i, new_slot[i], old_ids[i], kept[i] ? ST_OK : ST_MISS,
                      i + 1 == old_used);
      end
      default: push_result(0, 0, 0, ST_MISS, 1);
    endcase
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, field, got, want);
  endtask

  task automatic queue_req(logic [2:0] c, logic [15:0] id, logic [5:0] li,
                           logic [63:0] m, int gap, bit drain);
    palette_req_t q;
    q.command = c;
    q.global_id = id;
    q.local_index = li;
    q.used_mask = m;
    q.gap = gap;
    q.drain = drain;
    pending_reqs = {pending_reqs, q};
  endtask

  function automatic int pick_gap(int n, int total);
    if (n > total - 40) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 10);
    return 0;
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'hffff;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_command <= CMD_CLEAR;
      in_global_id <= '0;
      in_local_index <= '0;
      in_used_mask <= '0;
      hold_left <= 0;
    end else begin
      if (start && !busy) begin
        palette_update('{in_command, in_global_id, in_local_index, in_used_mask, 0, 0});
        reqs_taken++;
      end
      if ((start && !busy) || !start) begin
        if (hold_left > 0) begin
          hold_left <= hold_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && palette_expect.size() != 0)) begin
          in_command <= pending_reqs[0].command;
          in_global_id <= pending_reqs[0].global_id;
          in_local_index <= pending_reqs[0].local_index;
          in_used_mask <= pending_reqs[0].used_mask;
          hold_left <= pending_reqs[0].gap;
          void'(pending_reqs.pop_front());
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    palette_res_t w;
    if (rst_n && out_valid) begin
      results_seen++;
      if (palette_expect.size() == 0) begin
        errors++;
        $display("unexpected result, slot %0d status %0d", out_local_index_res, out_status);
      end else begin
        w = palette_expect.pop_front();
        if (out_local_index_res !== w.slot) report_mismatch("slot", out_local_index_res, w.slot);
        if (out_mapped_index !== w.mapped) report_mismatch("mapped", out_mapped_index, w.mapped);
        if (out_global_id_res !== w.id) report_mismatch("id", out_global_id_res, w.id);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_bits_needed !== w.bits) report_mismatch("bits", out_bits_needed, w.bits);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("palette_index_table regression: fail");
      $finish;
    end
  end

  initial begin
    int total;
    int r;
    palette_req_t q;
    errors = 0;
    reqs_taken = 0;
    results_seen = 0;
    full_seen = 0;
    compacts_seen = 0;
    stall_cycles = 0;
    slot_ids[0] = 16'd0;
    slots_used = 1;
    top_slot = 0;
    freed_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_CLEAR;
    in_global_id = '0;
    in_local_index = '0;
    in_used_mask = '0;

    // directed
    queue_req(CMD_ADD, 16'd0, 0, 0, 0, 0);
    queue_req(CMD_ADD, 16'hffff, 0, 0, 0, 0);
    queue_req(CMD_ADD, 16'd1, 0, 0, 2, 0);
    queue_req(CMD_ADD, 16'h8000, 0, 0, 0, 0);
    queue_req(CMD_ADD, 16'd1, 0, 0, 0, 0);
    queue_req(CMD_ID2SLOT, 16'h8000, 0, 0, 0, 0);
    queue_req(CMD_ID2SLOT, 16'h1234, 0, 0, 0, 0);
    queue_req(CMD_SLOT2ID, 0, 6'd1, 0, 0, 0);
    queue_req(CMD_SLOT2ID, 0, 6'd63, 0, 0, 0);
    queue_req(CMD_REMOVE, 16'd0, 0, 0, 0, 0);
    queue_req(CMD_REMOVE, 16'h1234, 0, 0, 0, 0);
    queue_req(CMD_REMOVE, 16'd1, 0, 0, 0, 1);
    queue_req(CMD_REMOVE, 16'hffff, 0, 0, 0, 0);
    queue_req(CMD_ADD, 16'h0055, 0, 0, 0, 0);
    queue_req(CMD_SLOT2ID, 0, 6'd2, 0, 0, 0);
    queue_req(CMD_COMPACT, 0, 0, 64'hffff_ffff_ffff_ffff, 0, 0);
    queue_req(CMD_ADD, 16'h00aa, 0, 0, 0, 0);
    queue_req(CMD_COMPACT, 0, 0, 64'd0, 3, 0);
    queue_req(CMD_SPARE_LO, 16'hffff, 6'h3f, 64'hffff_ffff_ffff_ffff, 0, 0);
    queue_req(CMD_SPARE_HI, 0, 0, 0, 0, 0);
    queue_req(CMD_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < 64; i++) queue_req(CMD_ADD, 16'(100 + i), 0, 0, pick_gap(0, 1), 0);
    queue_req(CMD_ADD, 16'h7777, 0, 0, 0, 0);
    queue_req(CMD_SLOT2ID, 0, 6'd63, 0, 0, 0);
    queue_req(CMD_REMOVE, 16'd130, 0, 0, 0, 0);
    queue_req(CMD_ADD, 16'h7777, 0, 0, 0, 0);
    queue_req(CMD_COMPACT, 0, 0, 64'haaaa_5555_f0f0_0f0f, 0, 1);

    // random
    total = 160;
    for (int n = 0; n < total; n++) begin
      r = $urandom_range(0, 99);
      q.global_id = pick_id();
      q.local_index = 6'($urandom_range(0, 63));
      q.used_mask = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) q.used_mask = ~64'd0;
      if (r < 40) q.command = CMD_ADD;
      else if (r < 55) q.command = CMD_REMOVE;
      else if (r < 70) q.command = CMD_SLOT2ID;
      else if (r < 85) q.command = CMD_ID2SLOT;
      else if (r < 92) q.command = CMD_COMPACT;
      else if (r < 96) q.command = CMD_CLEAR;
      else q.command = (r < 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
      queue_req(q.command, q.global_id, q.local_index, q.used_mask, pick_gap(n, total),
                $urandom_range(0, 30) == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (palette_expect.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("%0d requests taken, %0d results checked", reqs_taken, results_seen);
    $display("%0d full-table adds, %0d compactions", full_seen, compacts_seen);
    if (errors == 0) begin
      $display("palette_index_table regression: pass");
    end else begin
      $display("palette_index_table regression: fail");
    end
    $finish;
  end

endmodule
